FILE: hdl/mspfp_pkg.sv
// ----------------------------------------------------------------------------
// mspfp_pkg
// Shared types, constants and the CRC-8 DVB-S2 byte update for the MSP v2
// frame parser.
// ----------------------------------------------------------------------------
package mspfp_pkg;

    localparam int MAX_PAYLOAD  = 64;
    localparam int HEADER_BYTES = 8;

    // Store depth and field widths follow the fixed result field widths.
    localparam int PAY_DEPTH = 64;
    localparam int IDX_W     = 6;
    localparam int LEN_W     = 7;
    localparam int HCNT_W    = 3;

    localparam logic [7:0] CRC_POLY    = 8'hD5;
    localparam logic [7:0] CRC_TOP     = 8'h80;
    localparam logic [7:0] SYNC_DOLLAR = 8'h24;
    localparam logic [7:0] SYNC_X      = 8'h58;
    localparam logic [7:0] TYPE_CMD    = 8'h3C;
    localparam logic [7:0] TYPE_RSP    = 8'h3E;

    // Header byte positions within the frame.
    localparam logic [HCNT_W-1:0] HDR_FLAGS   = 3'd3;
    localparam logic [HCNT_W-1:0] HDR_FUNC_LO = 3'd4;
    localparam logic [HCNT_W-1:0] HDR_FUNC_HI = 3'd5;
    localparam logic [HCNT_W-1:0] HDR_LEN_LO  = 3'd6;
    localparam logic [HCNT_W-1:0] HDR_LAST    = HCNT_W'(HEADER_BYTES - 1);

    localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

    // Controller to datapath commands.
    typedef struct packed {
        logic hdr_start;   // type byte ok: latch kind, clear crc and counters
        logic hdr_step;    // absorb one header byte
        logic pay_step;    // absorb one payload byte
        logic emit_start;  // clear result index
        logic emit_read;   // read store at result index
        logic emit_next;   // advance result index
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic is_dollar;
        logic is_x;
        logic is_type;
        logic hdr_last;
        logic len_zero;    // length from current byte is zero
        logic len_big;     // length from current byte exceeds maximum
        logic pay_last;
        logic crc_ok;
        logic emit_last;
    } sts_t;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_TOP) != 8'h00) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

FILE: hdl/mspfp_ctrl.sv
// ----------------------------------------------------------------------------
// mspfp_ctrl
// Frame state machine: sync search, header, payload, CRC check, result emit.
// ----------------------------------------------------------------------------
module mspfp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  mspfp_pkg::sts_t   sts,
    output mspfp_pkg::cmd_t   cmd
);
    import mspfp_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_START     = 8'b0000_0010,
        ST_GOTX      = 8'b0000_0100,
        ST_HEADER    = 8'b0000_1000,
        ST_PAYLOAD   = 8'b0001_0000,
        ST_CHECK     = 8'b0010_0000,
        ST_EMIT_RD   = 8'b0100_0000,
        ST_EMIT_SHOW = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   in_fire;

    assign s_ready = (state_reg != ST_EMIT_RD) && (state_reg != ST_EMIT_SHOW);
    assign m_valid = (state_reg == ST_EMIT_SHOW);
    assign in_fire = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire && sts.is_dollar) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if (in_fire) begin
                    if (sts.is_x) begin
                        state_next = ST_GOTX;
                    end else if (!sts.is_dollar) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_GOTX: begin
                if (in_fire) begin
                    if (sts.is_type) begin
                        cmd.hdr_start = 1'b1;
                        state_next    = ST_HEADER;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_HEADER: begin
                if (in_fire) begin
                    cmd.hdr_step = 1'b1;
                    if (sts.hdr_last) begin
                        if (sts.len_big) begin
                            state_next = ST_IDLE;
                        end else if (sts.len_zero) begin
                            state_next = ST_CHECK;
                        end else begin
                            state_next = ST_PAYLOAD;
                        end
                    end
                end
            end
            ST_PAYLOAD: begin
                if (in_fire) begin
                    cmd.pay_step = 1'b1;
                    if (sts.pay_last) begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (in_fire) begin
                    if (sts.crc_ok) begin
                        cmd.emit_start = 1'b1;
                        state_next     = ST_EMIT_RD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT_RD: begin
                cmd.emit_read = 1'b1;
                state_next    = ST_EMIT_SHOW;
            end
            ST_EMIT_SHOW: begin
                if (m_ready) begin
                    if (sts.emit_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.emit_next = 1'b1;
                        state_next    = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hdl/mspfp_dp.sv
// ----------------------------------------------------------------------------
// mspfp_dp
// Datapath: byte decode, running CRC, header registers, payload store and
// result fields.
// ----------------------------------------------------------------------------
module mspfp_dp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [7:0]                  rx_byte,
    input  mspfp_pkg::cmd_t             cmd,
    output mspfp_pkg::sts_t             sts,
    output logic                        frame_kind,
    output logic [7:0]                  frame_flags,
    output logic [15:0]                 function_id,
    output logic [mspfp_pkg::LEN_W-1:0] payload_length,
    output logic [mspfp_pkg::IDX_W-1:0] byte_index,
    output logic [7:0]                  payload_byte,
    output logic                        byte_valid,
    output logic                        last
);
    import mspfp_pkg::*;

    logic [HCNT_W-1:0] hdr_cnt_reg;
    logic [LEN_W-1:0]  pay_cnt_reg;
    logic [IDX_W-1:0]  k_reg;
    logic [7:0]        crc_reg;
    logic              kind_reg;
    logic [7:0]        flags_reg;
    logic [15:0]       function_reg;
    logic [15:0]       length_reg;
    logic [7:0]        rd_data_reg;
    logic [7:0]        store_mem [PAY_DEPTH];

    logic [15:0]       len_in;
    logic [7:0]        crc_upd;
    logic              len_is_zero;

    assign len_in      = {rx_byte, length_reg[7:0]};
    assign crc_upd     = crc8_step(crc_reg, rx_byte);
    assign len_is_zero = (length_reg[LEN_W-1:0] == '0);

    always_comb begin
        sts.is_dollar = (rx_byte == SYNC_DOLLAR);
        sts.is_x      = (rx_byte == SYNC_X);
        sts.is_type   = (rx_byte == TYPE_CMD) || (rx_byte == TYPE_RSP);
        sts.hdr_last  = (hdr_cnt_reg == HDR_LAST);
        sts.len_zero  = (len_in == 16'h0000);
        sts.len_big   = (len_in > MAX_LEN);
        sts.pay_last  = ((pay_cnt_reg + LEN_W'(1)) == length_reg[LEN_W-1:0]);
        sts.crc_ok    = (rx_byte == crc_reg);
        sts.emit_last = len_is_zero ||
                        (({1'b0, k_reg} + LEN_W'(1)) == length_reg[LEN_W-1:0]);
    end

    // Control counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_cnt_reg <= HDR_FLAGS;
            pay_cnt_reg <= '0;
            k_reg       <= '0;
        end else begin
            if (cmd.hdr_start) begin
                hdr_cnt_reg <= HDR_FLAGS;
                pay_cnt_reg <= '0;
            end else if (cmd.hdr_step) begin
                hdr_cnt_reg <= hdr_cnt_reg + HCNT_W'(1);
            end else if (cmd.pay_step) begin
                pay_cnt_reg <= pay_cnt_reg + LEN_W'(1);
            end
            if (cmd.emit_start) begin
                k_reg <= '0;
            end else if (cmd.emit_next) begin
                k_reg <= k_reg + IDX_W'(1);
            end
        end
    end

    // Header fields and CRC
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg     <= 1'b0;
            crc_reg      <= 8'h00;
            flags_reg    <= 8'h00;
            function_reg <= 16'h0000;
            length_reg   <= 16'h0000;
        end else begin
            if (cmd.hdr_start) begin
                kind_reg <= (rx_byte == TYPE_RSP);
                crc_reg  <= 8'h00;
            end else if (cmd.hdr_step || cmd.pay_step) begin
                crc_reg <= crc_upd;
            end
            if (cmd.hdr_step) begin
                case (hdr_cnt_reg)
                    HDR_FLAGS:   flags_reg          <= rx_byte;
                    HDR_FUNC_LO: function_reg[7:0]  <= rx_byte;
                    HDR_FUNC_HI: function_reg[15:8] <= rx_byte;
                    HDR_LEN_LO:  length_reg[7:0]    <= rx_byte;
                    default:     length_reg[15:8]   <= rx_byte;
                endcase
            end
        end
    end

    // Payload store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.pay_step) begin
            store_mem[pay_cnt_reg[IDX_W-1:0]] <= rx_byte;
        end
        if (cmd.emit_read) begin
            rd_data_reg <= store_mem[k_reg];
        end
    end

    assign frame_kind     = kind_reg;
    assign frame_flags    = flags_reg;
    assign function_id    = function_reg;
    assign payload_length = length_reg[LEN_W-1:0];
    assign byte_index     = k_reg;
    assign byte_valid     = !len_is_zero;
    assign payload_byte   = len_is_zero ? 8'h00 : rd_data_reg;
    assign last           = sts.emit_last;

endmodule

FILE: hdl/msp_v2_frame_parser.sv
// ----------------------------------------------------------------------------
// msp_v2_frame_parser
// MSP v2 frame decoder with CRC-8 DVB-S2 check, one result per payload byte.
// ----------------------------------------------------------------------------
// Input: one byte per cycle accepted while parsing; s_ready low while emitting.
// Output: after a good CRC byte, each result takes a registered store read
//   state then a show state; empty payload: one result, m_byte_valid low.
// m_valid rises after the CRC byte is accepted and the first read; each result
//   holds for m_ready; input resumes the cycle after the last result is taken.
// Reset: synchronous active-low aresetn returns to sync search, no clear pass.
// ----------------------------------------------------------------------------
module msp_v2_frame_parser (
    input  logic                        aclk,
    input  logic                        aresetn,
    // byte input channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [7:0]                  s_rx_byte,
    // result channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_frame_kind,
    output logic [7:0]                  m_frame_flags,
    output logic [15:0]                 m_function_id,
    output logic [mspfp_pkg::LEN_W-1:0] m_payload_length,
    output logic [mspfp_pkg::IDX_W-1:0] m_byte_index,
    output logic [7:0]                  m_payload_byte,
    output logic                        m_byte_valid,
    output logic                        m_last
);
    import mspfp_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequencer: owns the frame phase and both handshakes.
    mspfp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Datapath: CRC, header fields, payload store. Result fields are all
    // register driven and hold steady while m_valid waits on m_ready.
    mspfp_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .rx_byte        (s_rx_byte),
        .cmd            (cmd),
        .sts            (sts),
        .frame_kind     (m_frame_kind),
        .frame_flags    (m_frame_flags),
        .function_id    (m_function_id),
        .payload_length (m_payload_length),
        .byte_index     (m_byte_index),
        .payload_byte   (m_payload_byte),
        .byte_valid     (m_byte_valid),
        .last           (m_last)
    );

endmodule
